FILE: design/sld_pkg.sv
package sld_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned OffsetW = 11;
	localparam int unsigned StatusW = 3;
	localparam int unsigned PlenW   = 10;
	localparam int unsigned LimitW  = 11;
	localparam int unsigned FlenW   = 16;
	localparam int unsigned CfgIdxW = 1;

	localparam logic [ByteW-1:0] SYNC_FIRST  = 8'hAA;
	localparam logic [ByteW-1:0] SYNC_SECOND = 8'h55;
	localparam logic [ByteW-1:0] KIND_A      = 8'h80;
	localparam logic [ByteW-1:0] KIND_B      = 8'h00;

	localparam logic [LimitW-1:0]  LIMIT_RESET  = 11'd400;
	localparam logic [LimitW-1:0]  LIMIT_CAP    = 11'd1024;
	localparam logic [FlenW:0]     HEADER_BYTES = 17'd9;
	localparam logic [FlenW-1:0]   PLEN_MAX     = 16'd1023;

	localparam logic [OffsetW-1:0] OFS_SYNC2  = 11'd1;
	localparam logic [OffsetW-1:0] OFS_ADDR   = 11'd2;
	localparam logic [OffsetW-1:0] OFS_KIND   = 11'd3;
	localparam logic [OffsetW-1:0] OFS_LEN_HI = 11'd7;
	localparam logic [OffsetW-1:0] OFS_LEN_LO = 11'd8;

	localparam logic [CfgIdxW-1:0] REG_STATION_ADDRESS = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_LENGTH_LIMIT    = 1'd1;

	localparam logic [StatusW-1:0] ST_IDLE    = 3'd0;
	localparam logic [StatusW-1:0] ST_BYTE    = 3'd1;
	localparam logic [StatusW-1:0] ST_ACCEPT  = 3'd2;
	localparam logic [StatusW-1:0] ST_REJECT  = 3'd3;
	localparam logic [StatusW-1:0] ST_OVER    = 3'd4;
	localparam logic [StatusW-1:0] ST_BADSYNC = 3'd5;

	typedef struct packed {
		logic [ByteW-1:0]   echo_byte;
		logic [OffsetW-1:0] byte_offset;
		logic [StatusW-1:0] status;
		logic [PlenW-1:0]   payload_length;
	} sld_result_t;

endpackage

FILE: design/sld_parse.sv
module sld_parse
	import sld_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [ByteW-1:0]   rx_byte,
	input  logic [ByteW-1:0]   station_address,
	input  logic [LimitW-1:0]  length_limit,
	output sld_result_t        result
);

	logic               in_frame_q,     in_frame_d;
	logic [OffsetW-1:0] byte_count_q,   byte_count_d;
	logic [ByteW-1:0]   length_high_q,  length_high_d;
	logic [FlenW-1:0]   frame_length_q, frame_length_d;
	logic               header_match_q, header_match_d;
	logic [ByteW-1:0]   address_seen_q, address_seen_d;

	logic [LimitW-1:0]  limit;
	logic [FlenW-1:0]   flen;
	logic [FlenW:0]     end_pos;
	logic [FlenW:0]     next_pos;

	always_comb begin
		limit    = (length_limit > LIMIT_CAP) ? LIMIT_CAP : length_limit;
		// length byte itself takes effect in the same byte
		flen     = (byte_count_q == OFS_LEN_LO) ? {length_high_q, rx_byte} : frame_length_q;
		end_pos  = {1'b0, flen} + HEADER_BYTES;
		next_pos = {{(FlenW + 1 - OffsetW){1'b0}}, byte_count_q} + 17'd1;

		in_frame_d     = in_frame_q;
		byte_count_d   = byte_count_q;
		length_high_d  = length_high_q;
		frame_length_d = frame_length_q;
		header_match_d = header_match_q;
		address_seen_d = address_seen_q;

		result.echo_byte      = rx_byte;
		result.byte_offset    = in_frame_q ? byte_count_q : '0;
		result.status         = ST_IDLE;
		result.payload_length = '0;

		if (!in_frame_q) begin
			if (rx_byte == SYNC_FIRST) begin
				in_frame_d     = 1'b1;
				byte_count_d   = 11'd1;
				length_high_d  = '0;
				frame_length_d = '0;
				header_match_d = 1'b0;
				address_seen_d = '0;
				result.status  = ST_BYTE;
			end
		end else if (byte_count_q == OFS_SYNC2 && rx_byte != SYNC_SECOND) begin
			result.status = ST_BADSYNC;
			in_frame_d    = 1'b0;
			byte_count_d  = '0;
		end else begin
			result.status = ST_BYTE;
			byte_count_d  = byte_count_q + 11'd1;
			case (byte_count_q)
				OFS_ADDR:   address_seen_d = rx_byte;
				OFS_KIND:   header_match_d = (rx_byte == KIND_A) || (rx_byte == KIND_B);
				OFS_LEN_HI: length_high_d  = rx_byte;
				OFS_LEN_LO: frame_length_d = flen;
				default:    ;
			endcase
			if (byte_count_q >= OFS_LEN_LO) begin
				result.payload_length = (flen > PLEN_MAX) ? PLEN_MAX[PlenW-1:0] : flen[PlenW-1:0];
				if (flen >= {{(FlenW - LimitW){1'b0}}, limit}) begin
					if (byte_count_q == OFS_LEN_LO) begin
						result.status = ST_OVER;
					end
					in_frame_d   = 1'b0;
					byte_count_d = '0;
				end else if (next_pos >= end_pos) begin
					result.status = (header_match_q && address_seen_q == station_address)
						? ST_ACCEPT : ST_REJECT;
					in_frame_d   = 1'b0;
					byte_count_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			byte_count_q   <= '0;
			length_high_q  <= '0;
			frame_length_q <= '0;
			header_match_q <= 1'b0;
			address_seen_q <= '0;
		end else if (step) begin
			in_frame_q     <= in_frame_d;
			byte_count_q   <= byte_count_d;
			length_high_q  <= length_high_d;
			frame_length_q <= frame_length_d;
			header_match_q <= header_match_d;
			address_seen_q <= address_seen_d;
		end
	end

endmodule

FILE: design/sync_length_frame_deframer.sv
// channel   dir  tdata (low bit up)                                  tuser
// s_axis    in   rx_byte[7:0]                                        -
// m_axis    out  echo_byte[7:0], byte_offset[18:8],                  status[2:0]
//                payload_length[28:19], zero pad [31:29]
// cfg       in   cfg_we, cfg_index (0 station_address, 1 length_limit), cfg_data[10:0]
//
// one byte per cycle sustained while m_axis drains; each byte is decoded in the cycle it transfers
// and its result lands in the output register on that edge.
// the input is ready whenever the output register is empty or drains in the same cycle.
// reset clears the frame state and the output valid; station_address returns to 0
// and length_limit to 400.
module sync_length_frame_deframer
	import sld_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // rx_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [31:0]         m_axis_tdata,   // echo_byte, byte_offset, payload_length
	output logic [StatusW-1:0]  m_axis_tuser,   // status
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [LimitW-1:0]   cfg_data
);

	logic [ByteW-1:0]  station_address_q;
	logic [LimitW-1:0] length_limit_q;
	logic              out_valid_q;
	sld_result_t       out_q;
	sld_result_t       result;
	logic              step;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign step          = s_axis_tvalid && s_axis_tready;

	sld_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.rx_byte         (s_axis_tdata),
		.station_address (station_address_q),
		.length_limit    (length_limit_q),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_address_q <= '0;
			length_limit_q    <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STATION_ADDRESS: station_address_q <= cfg_data[ByteW-1:0];
				REG_LENGTH_LIMIT:    length_limit_q    <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.payload_length, out_q.byte_offset, out_q.echo_byte};
	assign m_axis_tuser  = out_q.status;

endmodule

FILE: design/sld_checker.sv
module sld_checker
	import sld_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [31:0]        m_axis_tdata,
	input logic [StatusW-1:0] m_axis_tuser
);

	logic [OffsetW-1:0] ofs;
	logic [PlenW-1:0]   plen;

	assign ofs  = m_axis_tdata[18:8];
	assign plen = m_axis_tdata[28:19];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// hunting bytes carry no position or length
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_IDLE |-> ofs == '0 && plen == '0)
		else $error("hunting byte with offset or length");

	// length is unknown before the low length byte
	a_plen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ofs < OFS_LEN_LO |-> plen == '0)
		else $error("payload length shown before offset 8");

	// drop codes appear only at their own header positions
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != ST_BADSYNC || ofs == OFS_SYNC2)
			&& (m_axis_tuser != ST_OVER || ofs == OFS_LEN_LO))
		else $error("drop status at wrong offset");

endmodule

bind sync_length_frame_deframer sld_checker u_sld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sld_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;   // rx_byte
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [31:0]         m_axis_tdata;        // echo_byte, byte_offset, payload_length, pad
	logic [StatusW-1:0]  m_axis_tuser;        // status
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [LimitW-1:0]   cfg_data = '0;

	sync_length_frame_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder shadow: register copies and frame tracking
	logic [ByteW-1:0]   cur_station = '0;
	logic [LimitW-1:0]  cur_limit = LIMIT_RESET;
	logic               trk_in_frame = 1'b0;
	logic [OffsetW-1:0] trk_count = '0;
	logic [ByteW-1:0]   trk_len_hi = '0;
	logic [FlenW-1:0]   trk_len = '0;
	logic               trk_kind_ok = 1'b0;
	logic [ByteW-1:0]   trk_addr = '0;

	sld_result_t  pending_results[$];
	int unsigned  tx_idle_pct = 19;
	int unsigned  rx_idle_pct = 67;
	logic         hold_req = 1'b0;
	int unsigned  frame_bytes = 0;
	int unsigned  bytes_sent = 0;
	int unsigned  results_seen = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  long_left = 3;
	int unsigned  status_seen[8];

	typedef struct packed {
		logic [ByteW-1:0]   rx_byte;
		logic               typed;
		logic [OffsetW-1:0] ofs;
		logic [StatusW-1:0] st;
		logic [PlenW-1:0]   plen;
	} dir_row_t;

	dir_row_t directed_rows[31] = '{
		'{8'h00,       1'b1, 11'd0, ST_IDLE,    10'd0},
		'{SYNC_FIRST,  1'b1, 11'd0, ST_BYTE,    10'd0},
		// a second 0xAA is a bad sync byte and does not restart the frame
		'{SYNC_FIRST,  1'b1, 11'd1, ST_BADSYNC, 10'd0},
		'{8'hFF,       1'b1, 11'd0, ST_IDLE,    10'd0},
		// zero length, matching address, accepted on the length byte
		'{SYNC_FIRST,  1'b0, 11'd0, ST_IDLE,    10'd0},
		'{SYNC_SECOND, 1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h00,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{KIND_A,      1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h12,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h34,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h56,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h00,       1'b1, 11'd7, ST_BYTE,    10'd0},
		'{8'h00,       1'b1, 11'd8, ST_ACCEPT,  10'd0},
		// zero length, wrong address and kind, rejected
		'{SYNC_FIRST,  1'b0, 11'd0, ST_IDLE,    10'd0},
		'{SYNC_SECOND, 1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'hFF,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h01,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h00,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h00,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h00,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h00,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h00,       1'b1, 11'd8, ST_REJECT,  10'd0},
		// maximum length field, dropped with saturated length
		'{SYNC_FIRST,  1'b0, 11'd0, ST_IDLE,    10'd0},
		'{SYNC_SECOND, 1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'h00,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{KIND_B,      1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'hFF,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'hFF,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'hFF,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'hFF,       1'b0, 11'd0, ST_IDLE,    10'd0},
		'{8'hFF,       1'b1, 11'd8, ST_OVER,    10'd1023}
	};

	function automatic sld_result_t decode_byte(input logic [ByteW-1:0] b);
		sld_result_t        r;
		logic [OffsetW-1:0] ofs;
		logic [LimitW-1:0]  lim;
		r.echo_byte = b;
		r.byte_offset = '0;
		r.status = ST_IDLE;
		r.payload_length = '0;
		if (!trk_in_frame) begin
			if (b == SYNC_FIRST) begin
				trk_in_frame = 1'b1;
				trk_count = 11'd1;
				trk_len_hi = '0;
				trk_len = '0;
				trk_kind_ok = 1'b0;
				trk_addr = '0;
				r.status = ST_BYTE;
			end
		end else begin
			ofs = trk_count;
			r.byte_offset = ofs;
			if (ofs == OFS_SYNC2 && b != SYNC_SECOND) begin
				r.status = ST_BADSYNC;
				trk_in_frame = 1'b0;
				trk_count = '0;
			end else begin
				lim = (cur_limit > LIMIT_CAP) ? LIMIT_CAP : cur_limit;
				r.status = ST_BYTE;
				trk_count = ofs + 11'd1;
				case (ofs)
					OFS_ADDR:   trk_addr = b;
					OFS_KIND:   trk_kind_ok = (b == KIND_A || b == KIND_B);
					OFS_LEN_HI: trk_len_hi = b;
					OFS_LEN_LO: trk_len = {trk_len_hi, b};
					default: ;
				endcase
				if (ofs >= OFS_LEN_LO) begin
					r.payload_length = (trk_len > PLEN_MAX) ? '1 : trk_len[PlenW-1:0];
					if (int'(trk_len) >= int'(lim)) begin
						if (ofs == OFS_LEN_LO)
							r.status = ST_OVER;
						trk_in_frame = 1'b0;
						trk_count = '0;
					end else if (int'(ofs) + 1 >= int'(trk_len) + int'(HEADER_BYTES)) begin
						r.status = (trk_kind_ok && trk_addr == cur_station) ? ST_ACCEPT
							: ST_REJECT;
						trk_in_frame = 1'b0;
						trk_count = '0;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch at result %0d: %s is %0d, expected %0d", results_seen, what, got,
			want);
		mismatch_count++;
	endtask

	// one transfer in; the shadow decoder runs at the accepting edge
	task automatic send_byte(input logic [ByteW-1:0] b, input logic use_typed,
			input sld_result_t typed_res);
		sld_result_t pred;
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 20)
			gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		pred = decode_byte(b);
		bytes_sent++;
		if (pred.status != ST_IDLE)
			frame_bytes++;
		pending_results.push_back(use_typed ? typed_res : pred);
	endtask

	task automatic send_plain(input logic [ByteW-1:0] b);
		send_byte(b, 1'b0, '0);
	endtask

	task automatic send_frame();
		logic [ByteW-1:0] addr;
		logic [ByteW-1:0] kind_byte;
		int               eff;
		int               len;
		int unsigned      pick;
		eff = int'((cur_limit > LIMIT_CAP) ? LIMIT_CAP : cur_limit);
		addr = ($urandom_range(3) != 0) ? cur_station : 8'($urandom);
		case ($urandom_range(3))
			0: kind_byte = KIND_A;
			1: kind_byte = KIND_B;
			2: kind_byte = 8'($urandom);
			default: kind_byte = $urandom_range(1) ? KIND_A : KIND_B;
		endcase
		pick = $urandom_range(99);
		if (pick < 65)
			len = $urandom_range(24);
		else if (pick < 80)
			len = eff - 1 + int'($urandom_range(2));
		else if (pick < 90)
			len = $urandom_range(1023);
		else if (pick < 96)
			len = $urandom_range(65535);
		else
			len = $urandom_range(120, 25);
		if (len < 0)
			len = 0;
		// only a few frames may carry a long payload
		if (len < eff && len > 120) begin
			if (long_left == 0)
				len = $urandom_range(24);
			else
				long_left--;
		end
		send_plain(SYNC_FIRST);
		if ($urandom_range(19) == 0) begin
			send_plain(8'($urandom));
			return;
		end
		send_plain(SYNC_SECOND);
		send_plain(addr);
		send_plain(kind_byte);
		repeat (3) send_plain(8'($urandom));
		send_plain(len[15:8]);
		send_plain(len[7:0]);
		if (len < eff)
			repeat (len) send_plain(8'($urandom));
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_config(input logic [ByteW-1:0] station, input logic [LimitW-1:0] limit);
		cfg_we <= 1'b1;
		cfg_index <= REG_STATION_ADDRESS;
		// upper data bits are don't-care for the address register
		cfg_data <= {3'($urandom), station};
		@(posedge clk);
		cfg_index <= REG_LENGTH_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_station = station;
		cur_limit = limit;
	endtask

	// receiver: random backpressure, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = 400;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// result checker
	initial begin
		sld_result_t got;
		sld_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.echo_byte = m_axis_tdata[ByteW-1:0];
				got.byte_offset = m_axis_tdata[ByteW+OffsetW-1:ByteW];
				got.payload_length = m_axis_tdata[ByteW+OffsetW+PlenW-1:ByteW+OffsetW];
				got.status = m_axis_tuser;
				status_seen[got.status]++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected transfer, echo byte", got.echo_byte, 0);
				end else begin
					want = pending_results.pop_front();
					if (got.echo_byte !== want.echo_byte)
						report_mismatch("echo_byte", got.echo_byte, want.echo_byte);
					if (got.byte_offset !== want.byte_offset)
						report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.payload_length !== want.payload_length)
						report_mismatch("payload_length", got.payload_length,
							want.payload_length);
				end
				results_seen++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout: handshakes stopped");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		sld_result_t        row_res;
		logic [ByteW-1:0]   station;
		logic [LimitW-1:0]  limit;
		int unsigned        target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row_res.echo_byte = directed_rows[i].rx_byte;
			row_res.byte_offset = directed_rows[i].ofs;
			row_res.status = directed_rows[i].st;
			row_res.payload_length = directed_rows[i].plen;
			send_byte(directed_rows[i].rx_byte, directed_rows[i].typed, row_res);
		end
		s_axis_tvalid <= 1'b0;

		for (int ph = 1; ph <= 9; ph++) begin
			wait_drained();
			station = 8'($urandom);
			case (ph)
				1: begin station = 8'hFF; limit = LIMIT_CAP; end
				2: begin station = 8'h00; limit = 11'd1; end
				3: limit = 11'd0;
				4: limit = 11'd2047;
				5: limit = 11'($urandom_range(64, 9));
				6: limit = LIMIT_RESET;
				7: limit = 11'($urandom_range(1024, 1));
				8: limit = 11'($urandom_range(200, 20));
				default: limit = 11'($urandom_range(1024, 1000));
			endcase
			if (ph <= 3) begin
				tx_idle_pct = 19;
				rx_idle_pct = 67;
			end else if (ph <= 6) begin
				tx_idle_pct = 67;
				rx_idle_pct = 19;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			set_config(station, limit);
			// block the output for a while and keep offering bytes
			if (ph == 5)
				hold_req = 1'b1;
			target = frame_bytes + 225;
			while (frame_bytes < target) begin
				if ($urandom_range(9) < 3)
					repeat ($urandom_range(3, 1)) send_plain(8'($urandom));
				send_frame();
			end
			s_axis_tvalid <= 1'b0;
		end

		for (int i = 0; i < 20000 && pending_results.size() != 0; i++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered, count", pending_results.size(), 0);
		$display("%0d bytes in (%0d inside frames), %0d transfers out, 9 register settings",
			bytes_sent, frame_bytes, results_seen);
		$display("ends: %0d accepted, %0d rejected, %0d over limit, %0d bad sync",
			status_seen[ST_ACCEPT], status_seen[ST_REJECT], status_seen[ST_OVER],
			status_seen[ST_BADSYNC]);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
